[hw/rtl/feistel_block_cipher_64_assert.svh]
// Assertion macros for the feistel cipher RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef FEISTEL_BLOCK_CIPHER_64_ASSERT_SVH
`define FEISTEL_BLOCK_CIPHER_64_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define FBC64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, but also checked during reset.
`define FBC64_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/fbc64_pkg.sv]
// Types, constants and key schedule helpers for the 64-bit feistel cipher.
// No dependencies.
package fbc64_pkg;

  localparam int BLK_W    = 64;
  localparam int HALF_W   = 32;
  localparam int KEY_W    = 56;
  localparam int OFF_W    = 8;
  localparam int ROT_W    = 4;   // rotation amount in nibbles, 0..13
  localparam int ADDR_W   = 4;
  localparam int PDATA_W  = 64;

  localparam logic [3:0] ROT_STEPS = 4'd14;

  // Register indexes (byte address >> 3)
  localparam logic REG_KEY = 1'b0;
  localparam logic REG_OFF = 1'b1;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [BLK_W-1:0]  blk;
  } stage_t;

  // t mod 14 for an 8-bit t: reciprocal estimate (73/1024 < 1/14), then one fixup.
  function automatic logic [ROT_W-1:0] mod14(input logic [OFF_W-1:0] t);
    logic [14:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    prod = 15'(t) * 15'd73;
    q    = prod[14:10];
    r    = t - 8'(q) * 8'd14;
    if (r >= 8'(ROT_STEPS)) begin
      r = r - 8'(ROT_STEPS);
    end
    return r[ROT_W-1:0];
  endfunction

  // Round key: low half of the key rotated left by 4*(|off - idx| mod 14) within 56 bits.
  function automatic logic [HALF_W-1:0] round_key(input logic [KEY_W-1:0] key,
                                                  input logic [OFF_W-1:0] off,
                                                  input logic [OFF_W-1:0] idx);
    logic [OFF_W-1:0]   t;
    logic [ROT_W-1:0]   r;
    logic [6:0]         shamt;
    logic [2*KEY_W-1:0] dbl;
    t     = (off >= idx) ? (off - idx) : (idx - off);
    r     = mod14(t);
    shamt = 7'(KEY_W) - {1'b0, r, 2'b00};
    dbl   = {key, key} >> shamt;
    return dbl[HALF_W-1:0];
  endfunction

endpackage

[hw/rtl/feistel_block_cipher_64.sv]
// Top level of the 64-bit feistel cipher: round pipeline, output skid, APB registers.
// Depends on fbc64_pkg and feistel_block_cipher_64_assert.svh.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------
//  in      | in_valid / in_stall    | in_cmd, in_data_block
//  out     | out_valid / out_stall  | out_result_block
//  cfg     | psel/penable/pwrite    | paddr, pwdata, prdata (pready=1)
//
// One block accepted per cycle while in_stall is low; there is an input register
// and one register per round.  Round keys are registered from the config values.
// Synchronous active-low reset clears the valid bits and config registers to zero.
// A stalled result goes to a skid register; the pipeline freezes only once
// the skid is occupied, and in_stall is then raised.
module feistel_block_cipher_64 #(
  parameter int ROUNDS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [fbc64_pkg::BLK_W-1:0]    in_data_block,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fbc64_pkg::BLK_W-1:0]    out_result_block,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fbc64_pkg::ADDR_W-1:0]   paddr,
  input  logic [fbc64_pkg::PDATA_W-1:0]  pwdata,
  output logic [fbc64_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready
);
  import fbc64_pkg::*;

  `include "feistel_block_cipher_64_assert.svh"

  // Config registers
  logic [KEY_W-1:0] key_r;
  logic [OFF_W-1:0] off_r;
  logic             reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      off_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_KEY: key_r <= pwdata[KEY_W-1:0];
        REG_OFF: off_r <= pwdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KEY: prdata = PDATA_W'(key_r);
      REG_OFF: prdata = PDATA_W'(off_r);
      default: prdata = '0;
    endcase
  end

  // Round keys, one register per round
  logic [HALF_W-1:0] rkey_r [ROUNDS];

  // Pipeline: stg_r[s] holds the state before round s
  stage_t            stg_r   [ROUNDS];
  stage_t            stg_nxt [ROUNDS];
  logic [ROUNDS-1:0] stg_vld_r;
  stage_t            rnd_out [ROUNDS];

  logic              adv;
  logic [BLK_W-1:0]  out_r,  out_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [BLK_W-1:0]  skid_r, skid_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  logic              res_vld;

  assign adv      = !skid_vld_r;
  assign in_stall = skid_vld_r;
  assign res_vld  = stg_vld_r[ROUNDS-1];

  for (genvar s = 0; s < ROUNDS; s++) begin : g_round
    logic [HALF_W-1:0] lh, rh, mix;

    always_ff @(posedge clk) begin
      rkey_r[s] <= round_key(key_r, off_r, OFF_W'(s));
    end

    assign lh  = stg_r[s].blk[BLK_W-1:HALF_W];
    assign rh  = stg_r[s].blk[HALF_W-1:0];
    assign mix = lh ^ rh ^ rkey_r[s];

    always_comb begin
      rnd_out[s].cmd = stg_r[s].cmd;
      unique case (stg_r[s].cmd)
        CMD_ENC: rnd_out[s].blk = {rh, mix};
        CMD_DEC: rnd_out[s].blk = {mix, lh};
        default: rnd_out[s].blk = stg_r[s].blk;
      endcase
    end

    if (s == 0) begin : g_first
      assign stg_nxt[s] = '{cmd: in_cmd, blk: in_data_block};
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_vld_r[s] <= 1'b0;
        end else if (adv) begin
          stg_vld_r[s] <= in_valid;
        end
      end
    end else begin : g_rest
      assign stg_nxt[s] = rnd_out[s-1];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_vld_r[s] <= 1'b0;
        end else if (adv) begin
          stg_vld_r[s] <= stg_vld_r[s-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  // Output register with skid
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        out_nxt     = rnd_out[ROUNDS-1].blk;
        out_vld_nxt = res_vld;
      end
    end else if (adv && res_vld) begin
      // output held: park the finished transaction
      skid_nxt     = rnd_out[ROUNDS-1].blk;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_result_block = out_r;

  `FBC64_ASSERT(a_skid_needs_out, skid_vld_r |-> out_vld_r, "skid full while output empty")
  `FBC64_ASSERT(a_skid_on_stall, $rose(skid_vld_r) |-> $past(out_vld_r && out_stall), "skid loaded without output stall")
  `FBC64_ASSERT(a_pipe_frozen, skid_vld_r |=> $stable(stg_vld_r), "pipeline moved while skid full")

endmodule
